// ===== rtl/sbc_pkg.sv =====
// Shared types, constants and helpers for the split band chorus block.
// No dependencies; used by sbc_lfo and split_band_chorus_unit.
package sbc_pkg;

   localparam int MUL_A_BITS = 33;
   localparam int MUL_B_BITS = 22;
   localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;

   localparam logic [MUL_B_BITS-1:0] SVF_DAMP   = 22'd46334;
   localparam logic [16:0]           COEFF_ONE  = 17'd65536;
   localparam logic [31:0]           LFSR_MASK  = 32'hA300_0000;
   localparam logic [31:0]           LFSR_SEED  = 32'd12345;

   localparam logic [2:0] REG_SVF_COEFF    = 3'd0;
   localparam logic [2:0] REG_LFO_PERIOD   = 3'd1;
   localparam logic [2:0] REG_SMOOTH_COEFF = 3'd2;
   localparam logic [2:0] REG_DELAY_CENTER = 3'd3;
   localparam logic [2:0] REG_MOD_SPAN     = 3'd4;
   localparam logic [2:0] REG_DELAY_MIN    = 3'd5;
   localparam logic [2:0] REG_DELAY_MAX    = 3'd6;
   localparam logic [2:0] REG_WET_MIX      = 3'd7;

   localparam logic [16:0] RST_SVF_COEFF    = 17'd2570;
   localparam logic [19:0] RST_LFO_PERIOD   = 20'd24000;
   localparam logic [15:0] RST_SMOOTH_COEFF = 16'd68;
   localparam logic [19:0] RST_DELAY_CENTER = 20'd307200;
   localparam logic [19:0] RST_MOD_SPAN     = 20'd61440;
   localparam logic [19:0] RST_DELAY_MIN    = 20'd61440;
   localparam logic [19:0] RST_DELAY_MAX    = 20'd552960;
   localparam logic [16:0] RST_WET_MIX      = 17'd32768;

   typedef logic signed [MUL_A_BITS-1:0] mul_a_type;
   typedef logic signed [MUL_B_BITS-1:0] mul_b_type;
   typedef logic signed [MUL_P_BITS-1:0] mul_p_type;

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [39:0] hi;
      logic signed [39:0] lo;
      hi = 40'sd2147483647;
      lo = -40'sd2147483648;
      if (v > hi) begin
         return 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

endpackage

// ===== rtl/sbc_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module sbc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sbc_lfo.sv =====
// Random sample-and-hold LFO target: period counter and Galois LFSR.
// Depends on sbc_pkg.
module sbc_lfo (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [19:0]        period,
   output logic signed [15:0] target
);

   logic [19:0]        counter_ff;
   logic [31:0]        lfsr_ff;
   logic signed [15:0] target_ff;
   logic [20:0]        count_in;
   logic [31:0]        lfsr_in;
   logic               wrap;

   always_comb begin
      count_in = {1'b0, counter_ff} + 21'd1;
      wrap     = count_in >= {1'b0, period};
      if (wrap) begin
         count_in = count_in - {1'b0, period};
      end
      lfsr_in = {1'b0, lfsr_ff[31:1]} ^ (lfsr_ff[0] ? sbc_pkg::LFSR_MASK : 32'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
         lfsr_ff    <= sbc_pkg::LFSR_SEED;
         target_ff  <= '0;
      end else if (step && period != 20'd0) begin
         counter_ff <= count_in[19:0];
         if (wrap) begin
            lfsr_ff   <= lfsr_in;
            target_ff <= $signed(lfsr_in[31:16]);
         end
      end
   end

   assign target = target_ff;

endmodule

// ===== rtl/split_band_chorus_unit.sv =====
// Top level of the split band chorus: filter, LFO smoothing, delay ring and mix.
// Depends on sbc_pkg, sbc_lfo and sbc_ram.

// Each sample passes through the sequencer states in order, from acceptance
// to result. The wrap state repeats, adding one ring length each time, while
// the modulated delay reaches back past the start of the ring; at the default
// ring one addition is always enough. A new sample is taken only after the
// previous result is in the output register. The design uses one shared 33 x 22
// multiplier, which forms each product in turn, and the delay ring's single read port.
// No clearing pass follows reset: entries not yet written since reset read as
// zero. Input is taken only while the sequencer is idle. A finished result
// waits in the output register while the next sample is accepted.
module split_band_chorus_unit #(
   parameter int DELAY_DEPTH = 4096,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_sample_in,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SAMPLE_BITS-1:0] rsp_sample_out,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [7:0]             csr_index,
   input  logic [31:0]            csr_data
);

   localparam int AW   = $clog2(DELAY_DEPTH);
   localparam int PW   = ((AW + 8 > 20) ? AW + 8 : 20) + 2;
   localparam logic signed [PW-1:0] SPAN = PW'(DELAY_DEPTH * 256);
   localparam logic [AW-1:0] LAST = AW'(DELAY_DEPTH - 1);
   localparam logic signed [39:0] SB_MAX = (40'sd1 <<< (SAMPLE_BITS - 1)) - 40'sd1;
   localparam logic signed [39:0] SB_MIN = -(40'sd1 <<< (SAMPLE_BITS - 1));

   typedef enum logic [4:0] {
      S_IDLE, S_LOW, S_HIGH, S_SMOOTH, S_BP, S_DSUM, S_CLAMP, S_POS, S_WRAP,
      S_RD1, S_RD2, S_RD3, S_TAP, S_MIX1, S_MIX2, S_OUT
   } state_type;

   function automatic logic [SAMPLE_BITS-1:0] sat_sb(input logic signed [39:0] v);
      logic signed [39:0] r;
      r = v;
      if (v > SB_MAX) begin
         r = SB_MAX;
      end else if (v < SB_MIN) begin
         r = SB_MIN;
      end
      return r[SAMPLE_BITS-1:0];
   endfunction

   state_type state_ff;

   logic [16:0] svf_coeff_ff;
   logic [19:0] lfo_period_ff;
   logic [15:0] smooth_coeff_ff;
   logic [19:0] delay_center_ff;
   logic [19:0] mod_span_ff;
   logic [19:0] delay_min_ff;
   logic [19:0] delay_max_ff;
   logic [16:0] wet_mix_ff;

   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic signed [31:0]            low_state_ff;
   logic signed [31:0]            bp_state_ff;
   logic signed [31:0]            high_ff;
   logic signed [23:0]            smoothed_ff;
   logic signed [32:0]            diff_ff;
   logic signed [22:0]            dsum_ff;
   logic [19:0]                   delay_ff;
   logic signed [PW-1:0]          pos_ff;
   logic [AW-1:0]                 wp_ff;
   logic                          full_ff;
   logic [AW-1:0]                 i1_ff;
   logic [AW-1:0]                 i2_ff;
   logic [7:0]                    fr_ff;
   logic signed [SAMPLE_BITS-1:0] dry_ff;
   logic signed [32:0]            tap_ff;
   logic signed [39:0]            mix_ff;
   sbc_pkg::mul_p_type            prod_ff;
   sbc_pkg::mul_p_type            acc_ff;
   logic                          rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]        rsp_data_ff;

   sbc_pkg::mul_a_type            mul_a;
   sbc_pkg::mul_b_type            mul_b;
   sbc_pkg::mul_p_type            prod_in;
   logic [16:0]                   coeff;
   logic signed [31:0]            low_in;
   logic signed [31:0]            high_in;
   logic signed [31:0]            bp_in;
   logic signed [22:0]            clamp_in;
   logic [SAMPLE_BITS-1:0]        dry_in;
   logic [AW-1:0]                 i2_in;
   logic [AW-1:0]                 wp_in;
   logic [AW-1:0]                 rd_addr;
   logic [SAMPLE_BITS-1:0]        rd_data;
   logic signed [SAMPLE_BITS-1:0] ring_word;
   logic                          ring_ok;
   logic                          accept;
   logic                          out_free;
   logic signed [15:0]            lfo_target;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;
   assign coeff     = (svf_coeff_ff > sbc_pkg::COEFF_ONE) ? sbc_pkg::COEFF_ONE : svf_coeff_ff;

   sbc_lfo u_lfo (
      .clock  (clock),
      .reset  (reset),
      .step   (accept),
      .period (lfo_period_ff),
      .target (lfo_target)
   );

   sbc_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DELAY_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (state_ff == S_CLAMP),
      .wr_addr (wp_ff),
      .wr_data (dry_in),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      rd_addr = (state_ff == S_RD2) ? i2_ff : i1_ff;
      ring_ok = full_ff || (((state_ff == S_RD2) ? i1_ff : i2_ff) <= wp_ff);
      ring_word = ring_ok ? $signed(rd_data) : '0;
      i2_in = (i1_ff == LAST) ? '0 : i1_ff + 1'b1;
      wp_in = (wp_ff == LAST) ? '0 : wp_ff + 1'b1;
      dry_in = sat_sb(40'(high_ff));

      low_in  = sbc_pkg::sat32(40'(low_state_ff) + 40'(prod_ff >>> 16));
      high_in = sbc_pkg::sat32(40'(x_ff) - 40'(low_state_ff) - 40'(prod_ff >>> 16));
      bp_in   = sbc_pkg::sat32(40'(bp_state_ff) + 40'(prod_ff >>> 16));

      clamp_in = dsum_ff;
      if (clamp_in < $signed({3'b0, delay_min_ff})) begin
         clamp_in = $signed({3'b0, delay_min_ff});
      end
      if (clamp_in > $signed({3'b0, delay_max_ff})) begin
         clamp_in = $signed({3'b0, delay_max_ff});
      end

      mul_a = 33'(bp_state_ff);
      mul_b = $signed({5'b0, coeff});
      case (state_ff)
         S_LOW: begin
            mul_b = $signed(sbc_pkg::SVF_DAMP);
         end
         S_HIGH: begin
            mul_a = diff_ff;
            mul_b = $signed({6'b0, smooth_coeff_ff});
         end
         S_SMOOTH: begin
            mul_a = 33'(high_ff);
         end
         S_BP: begin
            mul_a = 33'(smoothed_ff);
            mul_b = $signed({2'b0, mod_span_ff});
         end
         S_RD2: begin
            mul_a = 33'(ring_word);
            mul_b = $signed({13'b0, 9'd256 - {1'b0, fr_ff}});
         end
         S_RD3: begin
            mul_a = 33'(ring_word);
            mul_b = $signed({14'b0, fr_ff});
         end
         S_TAP: begin
            mul_a = 33'(dry_ff);
            mul_b = 22'($signed(18'sd65536 - $signed({1'b0, wet_mix_ff})));
         end
         S_MIX1: begin
            mul_a = tap_ff;
            mul_b = $signed({5'b0, wet_mix_ff});
         end
         default: begin
            mul_a = 33'(bp_state_ff);
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         svf_coeff_ff    <= sbc_pkg::RST_SVF_COEFF;
         lfo_period_ff   <= sbc_pkg::RST_LFO_PERIOD;
         smooth_coeff_ff <= sbc_pkg::RST_SMOOTH_COEFF;
         delay_center_ff <= sbc_pkg::RST_DELAY_CENTER;
         mod_span_ff     <= sbc_pkg::RST_MOD_SPAN;
         delay_min_ff    <= sbc_pkg::RST_DELAY_MIN;
         delay_max_ff    <= sbc_pkg::RST_DELAY_MAX;
         wet_mix_ff      <= sbc_pkg::RST_WET_MIX;
      end else if (csr_valid && csr_index[7:3] == 5'd0) begin
         case (csr_index[2:0])
            sbc_pkg::REG_SVF_COEFF:    svf_coeff_ff    <= csr_data[16:0];
            sbc_pkg::REG_LFO_PERIOD:   lfo_period_ff   <= csr_data[19:0];
            sbc_pkg::REG_SMOOTH_COEFF: smooth_coeff_ff <= csr_data[15:0];
            sbc_pkg::REG_DELAY_CENTER: delay_center_ff <= csr_data[19:0];
            sbc_pkg::REG_MOD_SPAN:     mod_span_ff     <= csr_data[19:0];
            sbc_pkg::REG_DELAY_MIN:    delay_min_ff    <= csr_data[19:0];
            sbc_pkg::REG_DELAY_MAX:    delay_max_ff    <= csr_data[19:0];
            sbc_pkg::REG_WET_MIX:      wet_mix_ff      <= csr_data[16:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE:   x_ff        <= $signed(req_sample_in);
         S_LOW:    diff_ff     <= (33'(lfo_target) <<< 8) - 33'(smoothed_ff);
         S_HIGH:   high_ff     <= high_in;
         S_DSUM:   dsum_ff     <= $signed({3'b0, delay_center_ff}) + 23'(prod_ff >>> 23);
         S_CLAMP: begin
            delay_ff <= clamp_in[19:0];
            dry_ff   <= $signed(dry_in);
         end
         S_WRAP: begin
            i1_ff <= pos_ff[AW+7:8];
            fr_ff <= pos_ff[7:0];
         end
         S_RD1:    i2_ff       <= i2_in;
         S_RD3:    acc_ff      <= prod_ff;
         S_TAP:    tap_ff      <= 33'((acc_ff + prod_ff) >>> 8);
         S_MIX1:   acc_ff      <= prod_ff;
         S_MIX2:   mix_ff      <= 40'((acc_ff + prod_ff) >>> 16);
         default: begin
         end
      endcase
      if (state_ff == S_POS) begin
         pos_ff <= $signed(PW'({wp_ff, 8'b0})) - $signed(PW'(delay_ff));
      end else if (state_ff == S_WRAP && pos_ff[PW-1]) begin
         pos_ff <= pos_ff + SPAN;
      end
      if (state_ff == S_OUT && out_free) begin
         rsp_data_ff <= sat_sb(40'(low_state_ff) + mix_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         low_state_ff <= '0;
         bp_state_ff  <= '0;
         smoothed_ff  <= '0;
         wp_ff        <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_LOW;
               end
            end
            S_LOW: begin
               low_state_ff <= low_in;
               state_ff     <= S_HIGH;
            end
            S_HIGH:   state_ff <= S_SMOOTH;
            S_SMOOTH: begin
               smoothed_ff <= smoothed_ff + 24'(prod_ff >>> 16);
               state_ff    <= S_BP;
            end
            S_BP: begin
               bp_state_ff <= bp_in;
               state_ff    <= S_DSUM;
            end
            S_DSUM:  state_ff <= S_CLAMP;
            S_CLAMP: state_ff <= S_POS;
            S_POS:   state_ff <= S_WRAP;
            S_WRAP: begin
               if (!pos_ff[PW-1]) begin
                  state_ff <= S_RD1;
               end
            end
            S_RD1:  state_ff <= S_RD2;
            S_RD2:  state_ff <= S_RD3;
            S_RD3:  state_ff <= S_TAP;
            S_TAP:  state_ff <= S_MIX1;
            S_MIX1: state_ff <= S_MIX2;
            S_MIX2: state_ff <= S_OUT;
            S_OUT: begin
               if (out_free) begin
                  wp_ff        <= wp_in;
                  if (wp_ff == LAST) begin
                     full_ff <= 1'b1;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

`ifndef SYNTHESIS
   a_delay_clamped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POS) |-> (delay_ff <= delay_max_ff))
      else $error("delay above upper clamp");

   a_tap_in_ring: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD1) |-> (i1_ff <= LAST))
      else $error("tap index outside ring");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && out_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("result not delivered");

   a_pointer_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_OUT) |=> (wp_ff == $past(wp_ff)))
      else $error("write pointer moved outside result step");
`endif

endmodule
